[rtl/gts_pkg.sv]
`timescale 1ns / 1ps
package gts_pkg;

  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 25;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_QUERY = 2'd2;

  localparam logic [2:0] REG_GRID_DIMS   = 3'd0;
  localparam logic [2:0] REG_CENTER_X    = 3'd1;
  localparam logic [2:0] REG_CENTER_Y    = 3'd2;
  localparam logic [2:0] REG_CENTER_Z    = 3'd3;
  localparam logic [2:0] REG_INV_PITCH_X = 3'd4;
  localparam logic [2:0] REG_INV_PITCH_Y = 3'd5;
  localparam logic [2:0] REG_INV_PITCH_Z = 3'd6;
  localparam logic [2:0] REG_LIMIT       = 3'd7;

  typedef enum logic [3:0] {
    S_IDLE,
    S_AX_MUL,
    S_AX_FIX,
    S_AD_XY,
    S_AD_Y,
    S_AD_S,
    S_WR,
    S_RDQ,
    S_RDR,
    S_STR,
    S_RD_A,
    S_RD_B,
    S_LZ_MUL,
    S_LZ_FIN,
    S_L_MUL,
    S_L_FIN
  } state_t;

endpackage

[rtl/gts_mul.sv]
`timescale 1ns / 1ps
module gts_mul (
  input  logic                                clk,
  input  logic signed [gts_pkg::MUL_A_W-1:0] a,
  input  logic signed [gts_pkg::MUL_B_W-1:0] b,
  output logic signed [gts_pkg::MUL_P_W-1:0] p
);
  import gts_pkg::*;

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

[rtl/gts_grid_ram.sv]
`timescale 1ns / 1ps
module gts_grid_ram #(
  parameter int DEPTH  = 262144,
  parameter int ADDR_W = 18,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[rtl/grid_trilinear_sampler.sv]
`timescale 1ns / 1ps
// Start accepted to done: a write keeps busy high, no result; a read inside the grid returns
// the stored value, one outside it the limit; a query does 3 axis and 3 address multiplies,
// then 8 corner reads and 7 blends, all on one shared multiplier and one single-port memory.
// Throughput: one item at a time; a new item is taken once busy is low.
// Reset returns the sequencer, the strobe and the configuration registers to their reset
// values; the grid memory is not cleared and holds nothing defined until written.
module grid_trilinear_sampler #(
  parameter int MAX_DIM = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         func,
  input  logic [6:0]         idx_x,
  input  logic [6:0]         idx_y,
  input  logic [6:0]         idx_z,
  input  logic signed [31:0] value,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  output logic               done,
  output logic signed [31:0] energy,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_idx,
  input  logic [31:0]        cfg_data
);
  import gts_pkg::*;

  localparam int DEPTH  = MAX_DIM * MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int IDX_W  = $clog2(MAX_DIM);
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam logic [1:0] LAST_AXIS   = 2'd2;
  localparam logic [1:0] LAST_CORNER = 2'd3;
  localparam logic [1:0] LAST_STEP   = 2'd2;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [6:0] f);
    logic [DIM_W-1:0] n;
    if (f < 7'd2) begin
      n = DIM_W'(2);
    end else if (32'(f) > MAX_DIM) begin
      n = DIM_W'(MAX_DIM);
    end else begin
      n = DIM_W'(f);
    end
    return n;
  endfunction

  function automatic logic signed [31:0] lerp_round(input logic signed [31:0] a,
                                                    input logic signed [MUL_P_W-1:0] pr);
    logic [50:0] s;
    s = {{3{a[31]}}, a, 16'b0} + pr[50:0] + 51'd32768;
    return $signed(s[47:16]);
  endfunction

  // configuration
  logic [20:0]        grid_dims;
  logic signed [31:0] center_x, center_y, center_z;
  logic [23:0]        inv_pitch_x, inv_pitch_y, inv_pitch_z;
  logic signed [31:0] outside_energy;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_dims      <= 21'd1049601;
      center_x       <= '0;
      center_y       <= '0;
      center_z       <= '0;
      inv_pitch_x    <= 24'd262144;
      inv_pitch_y    <= 24'd262144;
      inv_pitch_z    <= 24'd262144;
      outside_energy <= 32'sh7FFFFFFF;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_GRID_DIMS:   grid_dims      <= cfg_data[20:0];
        REG_CENTER_X:    center_x       <= $signed(cfg_data);
        REG_CENTER_Y:    center_y       <= $signed(cfg_data);
        REG_CENTER_Z:    center_z       <= $signed(cfg_data);
        REG_INV_PITCH_X: inv_pitch_x    <= cfg_data[23:0];
        REG_INV_PITCH_Y: inv_pitch_y    <= cfg_data[23:0];
        REG_INV_PITCH_Z: inv_pitch_z    <= cfg_data[23:0];
        REG_LIMIT:       outside_energy <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  logic [DIM_W-1:0] nx, ny, nz;
  assign nx = clamp_dim(grid_dims[6:0]);
  assign ny = clamp_dim(grid_dims[13:7]);
  assign nz = clamp_dim(grid_dims[20:14]);

  logic in_grid;
  assign in_grid = (32'(idx_x) < 32'(nx)) && (32'(idx_y) < 32'(ny)) && (32'(idx_z) < 32'(nz));

  // working registers
  state_t             state, state_next;
  logic [1:0]         op;
  logic [1:0]         ax;
  logic [1:0]         corner;
  logic [1:0]         step;
  logic [IDX_W-1:0]   ix, iy, iz;
  logic [16:0]        fx, fy, fz;
  logic signed [31:0] px, py, pz;
  logic [31:0]        wval;
  logic [ADDR_W-1:0]  base, stride;
  logic signed [31:0] la;
  logic signed [31:0] e [4];

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] prod;

  logic               mem_we;
  logic [ADDR_W-1:0]  mem_addr, corner_addr;
  logic [31:0]        rdata;

  gts_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  gts_grid_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (32)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (wval),
    .rdata (rdata)
  );

  // axis selection
  logic signed [31:0] sel_pos, sel_ctr;
  logic [23:0]        sel_inv;
  logic [DIM_W-1:0]   sel_n;

  always_comb begin
    case (ax)
      2'd0: begin
        sel_pos = px; sel_ctr = center_x; sel_inv = inv_pitch_x; sel_n = nx;
      end
      2'd1: begin
        sel_pos = py; sel_ctr = center_y; sel_inv = inv_pitch_y; sel_n = ny;
      end
      default: begin
        sel_pos = pz; sel_ctr = center_z; sel_inv = inv_pitch_z; sel_n = nz;
      end
    endcase
  end

  // cell and fraction from the scaled offset
  logic signed [58:0] real_v;
  logic [IDX_W-1:0]   cell_v;
  logic [16:0]        frac_v;

  always_comb begin
    real_v = {prod[MUL_P_W-1], prod} + $signed(59'({(DIM_W'(sel_n - DIM_W'(1)) >> 1), 32'b0}));
    priority if (real_v[58]) begin
      cell_v = '0;
      frac_v = '0;
    end else if (real_v[57:32] >= 26'(sel_n - DIM_W'(1))) begin
      cell_v = IDX_W'(sel_n - DIM_W'(2));
      frac_v = 17'h10000;
    end else begin
      cell_v = IDX_W'(real_v[57:32]);
      frac_v = {1'b0, real_v[31:16]};
    end
  end

  // blend operands
  logic signed [31:0] lerp_a, lerp_b;
  logic [16:0]        lerp_f;
  logic signed [32:0] diff_mem, diff_lerp;

  always_comb begin
    case (step)
      2'd0:    begin lerp_a = e[0]; lerp_b = e[1]; end
      2'd1:    begin lerp_a = e[2]; lerp_b = e[3]; end
      default: begin lerp_a = e[0]; lerp_b = e[1]; end
    endcase
    lerp_f    = (step == LAST_STEP) ? fx : fy;
    diff_mem  = $signed({rdata[31], rdata}) - $signed({la[31], la});
    diff_lerp = $signed({lerp_b[31], lerp_b}) - $signed({lerp_a[31], lerp_a});
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_AX_MUL: begin
        mul_a = $signed({sel_pos[31], sel_pos}) - $signed({sel_ctr[31], sel_ctr});
        mul_b = $signed(MUL_B_W'(sel_inv));
      end
      S_AD_XY: begin
        mul_a = $signed(MUL_A_W'(ix));
        mul_b = $signed(MUL_B_W'(ny));
      end
      S_AD_Y: begin
        mul_a = $signed(MUL_A_W'(prod[ADDR_W-1:0] + ADDR_W'(iy)));
        mul_b = $signed(MUL_B_W'(nz));
      end
      S_AD_S: begin
        mul_a = $signed(MUL_A_W'(ny));
        mul_b = $signed(MUL_B_W'(nz));
      end
      S_LZ_MUL: begin
        mul_a = diff_mem;
        mul_b = $signed(MUL_B_W'(fz));
      end
      S_L_MUL: begin
        mul_a = diff_lerp;
        mul_b = $signed(MUL_B_W'(lerp_f));
      end
      default: ;
    endcase
  end

  // memory port
  always_comb begin
    corner_addr = base + ((state == S_RD_B) ? ADDR_W'(1) : '0)
                + (corner[0] ? ADDR_W'(nz) : '0)
                + (corner[1] ? stride : '0);
    mem_we   = (state == S_WR);
    mem_addr = (state == S_WR || state == S_RDQ) ? base : corner_addr;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (func == FUNC_WRITE || func == FUNC_READ) begin
            if (in_grid) begin
              state_next = S_AD_XY;
            end
          end else if (func == FUNC_QUERY) begin
            state_next = S_AX_MUL;
          end
        end
      end
      S_AX_MUL: state_next = S_AX_FIX;
      S_AX_FIX: state_next = (ax == LAST_AXIS) ? S_AD_XY : S_AX_MUL;
      S_AD_XY:  state_next = S_AD_Y;
      S_AD_Y:   state_next = S_AD_S;
      S_AD_S: begin
        priority if (op == FUNC_WRITE) begin
          state_next = S_WR;
        end else if (op == FUNC_READ) begin
          state_next = S_RDQ;
        end else begin
          state_next = S_STR;
        end
      end
      S_WR:     state_next = S_IDLE;
      S_RDQ:    state_next = S_RDR;
      S_RDR:    state_next = S_IDLE;
      S_STR:    state_next = S_RD_A;
      S_RD_A:   state_next = S_RD_B;
      S_RD_B:   state_next = S_LZ_MUL;
      S_LZ_MUL: state_next = S_LZ_FIN;
      S_LZ_FIN: state_next = (corner == LAST_CORNER) ? S_L_MUL : S_RD_A;
      S_L_MUL:  state_next = S_L_FIN;
      S_L_FIN:  state_next = (step == LAST_STEP) ? S_IDLE : S_L_MUL;
      default:  state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == S_IDLE && start && func == FUNC_READ && !in_grid)
              || (state == S_RDR) || (state == S_L_FIN && step == LAST_STEP);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        op     <= func;
        ax     <= '0;
        corner <= '0;
        step   <= '0;
        ix     <= IDX_W'(idx_x);
        iy     <= IDX_W'(idx_y);
        iz     <= IDX_W'(idx_z);
        wval   <= value;
        px     <= pos_x;
        py     <= pos_y;
        pz     <= pos_z;
        energy <= outside_energy;
      end
      S_AX_FIX: begin
        ax <= ax + 2'd1;
        case (ax)
          2'd0:    begin ix <= cell_v; fx <= frac_v; end
          2'd1:    begin iy <= cell_v; fy <= frac_v; end
          default: begin iz <= cell_v; fz <= frac_v; end
        endcase
      end
      S_AD_S:   base   <= prod[ADDR_W-1:0] + ADDR_W'(iz);
      S_STR:    stride <= prod[ADDR_W-1:0];
      S_RDR:    energy <= $signed(rdata);
      S_RD_B:   la     <= $signed(rdata);
      S_LZ_FIN: begin
        e[corner] <= lerp_round(la, prod);
        corner    <= corner + 2'd1;
      end
      S_L_FIN: begin
        step <= step + 2'd1;
        case (step)
          2'd0:    e[0]   <= lerp_round(lerp_a, prod);
          2'd1:    e[1]   <= lerp_round(lerp_a, prod);
          default: energy <= lerp_round(lerp_a, prod);
        endcase
      end
      default: ;
    endcase
  end

endmodule
